/* rtl/bdeq_pkg.sv */
// ----------------------------------------------------------------------------
// bdeq_pkg
// shared types and codes of the bounded double-ended queue core
// ----------------------------------------------------------------------------
package bdeq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int WORD_W        = 32;
	localparam int KIND_W        = 3;

	// entries of the command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_AW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_SHOW       = 3'd4,
		KIND_CLEAR      = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_SHOW  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic                     at_front;
		logic signed [WORD_W-1:0] value;
	} cmd_t;

endpackage

/* rtl/bdeq_front.sv */
// ----------------------------------------------------------------------------
// bdeq_front
// accepts input words, decodes the kind and drops unknown kinds
// ----------------------------------------------------------------------------
module bdeq_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic signed [bdeq_pkg::WORD_W-1:0]     s_tdata,
	input  logic        [bdeq_pkg::KIND_W-1:0]     s_tuser,
	output logic                                   cmd_valid,
	input  logic                                   cmd_ready,
	output bdeq_pkg::cmd_t                         cmd
);

	logic           valid_s1;
	bdeq_pkg::cmd_t cmd_s1;
	bdeq_pkg::cmd_t dec_cmd;
	logic           dec_known;

	always_comb begin
		dec_cmd.op       = bdeq_pkg::OP_CLEAR;
		dec_cmd.at_front = 1'b0;
		dec_cmd.value    = s_tdata;
		dec_known        = 1'b1;
		unique case (s_tuser) inside
			bdeq_pkg::KIND_PUSH_FRONT, bdeq_pkg::KIND_PUSH_BACK: begin
				dec_cmd.op       = bdeq_pkg::OP_PUSH;
				dec_cmd.at_front = (s_tuser == bdeq_pkg::KIND_PUSH_FRONT);
			end
			bdeq_pkg::KIND_POP_FRONT, bdeq_pkg::KIND_POP_BACK: begin
				dec_cmd.op       = bdeq_pkg::OP_POP;
				dec_cmd.at_front = (s_tuser == bdeq_pkg::KIND_POP_FRONT);
			end
			bdeq_pkg::KIND_SHOW: begin
				dec_cmd.op = bdeq_pkg::OP_SHOW;
			end
			bdeq_pkg::KIND_CLEAR: begin
				dec_cmd.op = bdeq_pkg::OP_CLEAR;
			end
			default: begin
				dec_known = 1'b0;
			end
		endcase
	end

	assign s_tready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			// unknown kinds are taken and dropped here
			valid_s1 <= s_tvalid && dec_known;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= dec_cmd;
		end
	end

endmodule

/* rtl/bdeq_cmd_queue.sv */
// ----------------------------------------------------------------------------
// bdeq_cmd_queue
// short command queue that decouples the front from the back
// ----------------------------------------------------------------------------
module bdeq_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  bdeq_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output bdeq_pkg::cmd_t pop_cmd
);

	bdeq_pkg::cmd_t                    slots [bdeq_pkg::CQ_DEPTH];
	logic [bdeq_pkg::CQ_AW-1:0]        wr_ptr_q;
	logic [bdeq_pkg::CQ_AW-1:0]        rd_ptr_q;
	logic [bdeq_pkg::CQ_CW-1:0]        fill_q;
	logic                              do_push;
	logic                              do_pop;

	assign push_ready = (fill_q != bdeq_pkg::CQ_CW'(bdeq_pkg::CQ_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = slots[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [bdeq_pkg::CQ_AW-1:0] next_ptr(input logic [bdeq_pkg::CQ_AW-1:0] p);
		if (p == bdeq_pkg::CQ_AW'(bdeq_pkg::CQ_DEPTH - 1)) begin
			return '0;
		end
		return p + bdeq_pkg::CQ_AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + bdeq_pkg::CQ_CW'(1);
				2'b01:   fill_q <= fill_q - bdeq_pkg::CQ_CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/bdeq_back.sv */
// ----------------------------------------------------------------------------
// bdeq_back
// ring storage, front index and count; executes commands, drives results
// ----------------------------------------------------------------------------
module bdeq_back #(
	parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  bdeq_pkg::cmd_t                      cmd,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic signed [bdeq_pkg::WORD_W-1:0]  m_tdata,
	output logic        [1:0]                   m_tuser,
	output logic                                m_tlast
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SHOW
	} state_t;

	state_t                            state_q;
	logic [IDX_W-1:0]                  front_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  idx_q;
	logic signed [bdeq_pkg::WORD_W-1:0] mem [DEPTH];
	logic signed [bdeq_pkg::WORD_W-1:0] rdata_q;

	logic                              m_tvalid_q;
	logic signed [bdeq_pkg::WORD_W-1:0] m_tdata_q;
	bdeq_pkg::status_t                 m_tuser_q;
	logic                              m_tlast_q;

	logic                              slot_free;
	logic                              take;
	logic                              full;
	logic                              empty;
	logic                              show_last;
	logic [IDX_W-1:0]                  front_dec;
	logic [IDX_W-1:0]                  front_inc;
	logic [IDX_W-1:0]                  pos_back;
	logic [IDX_W-1:0]                  pos_last;
	logic [IDX_W-1:0]                  pos_show_next;
	logic                              wr_en;
	logic [IDX_W-1:0]                  wr_addr;
	logic                              rd_en;
	logic [IDX_W-1:0]                  rd_addr;

	function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
		return r[IDX_W-1:0];
	endfunction

	assign slot_free = !m_tvalid_q || m_tready;
	assign cmd_ready = (state_q == S_IDLE) && slot_free;
	assign take      = cmd_valid && cmd_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign show_last = (CNT_W'(idx_q + CNT_W'(1)) == count_q);

	assign front_dec     = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
	assign front_inc     = wrap(SUM_W'(front_q) + SUM_W'(1));
	assign pos_back      = wrap(SUM_W'(front_q) + SUM_W'(count_q));
	assign pos_last      = wrap(SUM_W'(front_q) + SUM_W'(count_q) - SUM_W'(1));
	assign pos_show_next = wrap(SUM_W'(front_q) + SUM_W'(idx_q) + SUM_W'(1));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_back;
		rd_en   = 1'b0;
		rd_addr = front_q;
		if (take) begin
			unique case (cmd.op)
				bdeq_pkg::OP_PUSH: begin
					wr_en   = !full;
					wr_addr = cmd.at_front ? front_dec : pos_back;
				end
				bdeq_pkg::OP_POP: begin
					rd_en   = !empty;
					rd_addr = cmd.at_front ? front_q : pos_last;
				end
				bdeq_pkg::OP_SHOW: begin
					rd_en   = !empty;
					rd_addr = front_q;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_SHOW && slot_free && !show_last) begin
			// fetch the next word while the current one goes out
			rd_en   = 1'b1;
			rd_addr = pos_show_next;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= bdeq_pkg::STATUS_OK;
			m_tlast_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						m_tdata_q <= '0;
						m_tlast_q <= 1'b1;
						m_tuser_q <= bdeq_pkg::STATUS_OK;
						unique case (cmd.op)
							bdeq_pkg::OP_PUSH: begin
								m_tvalid_q <= 1'b1;
								if (full) begin
									m_tuser_q <= bdeq_pkg::STATUS_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
									if (cmd.at_front) begin
										front_q <= front_dec;
									end
								end
							end
							bdeq_pkg::OP_POP: begin
								if (empty) begin
									m_tvalid_q <= 1'b1;
									m_tuser_q  <= bdeq_pkg::STATUS_EMPTY;
								end else begin
									count_q <= count_q - CNT_W'(1);
									if (cmd.at_front) begin
										front_q <= front_inc;
									end
									state_q <= S_POP;
								end
							end
							bdeq_pkg::OP_SHOW: begin
								if (empty) begin
									m_tvalid_q <= 1'b1;
									m_tuser_q  <= bdeq_pkg::STATUS_EMPTY;
								end else begin
									idx_q   <= '0;
									state_q <= S_SHOW;
								end
							end
							default: begin
								m_tvalid_q <= 1'b1;
								count_q    <= '0;
								front_q    <= '0;
							end
						endcase
					end
				end
				S_POP: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= rdata_q;
						m_tuser_q  <= bdeq_pkg::STATUS_OK;
						m_tlast_q  <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_SHOW: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= rdata_q;
						m_tuser_q  <= bdeq_pkg::STATUS_OK;
						m_tlast_q  <= show_last;
						if (show_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stored count above depth");

	a_show_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHOW) |-> (idx_q < count_q))
		else $error("show index past stored count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.op == bdeq_pkg::OP_CLEAR) |=> (count_q == '0 && front_q == '0))
		else $error("clear left words behind");

	a_pop_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.op == bdeq_pkg::OP_POP && !empty) |=> (state_q == S_POP && !m_tvalid_q))
		else $error("pop result slot not free");
`endif

endmodule

/* rtl/bounded_double_ended_queue_core.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core
// bounded deque of signed 32-bit words with push, pop, show and clear
// ----------------------------------------------------------------------------
// usage:
// commands enter on the s_ channel: s_tuser carries the kind, s_tdata the
// word to push. results leave on the m_ channel: m_tuser is the status,
// m_tdata the popped or shown word, m_tlast marks the final result of a
// command. unknown kinds are taken and produce nothing.
// a push, clear or refused command passes the front register, the command
// queue slot and the output register; a pop that finds a word also passes
// the registered ring read, and a show streams its words through that read.
// push and clear run one per cycle while m_tready holds; a pop with a word
// waits in the pop state and a show in its show state until the last word
// is out, all set by the back-end sequencer and its single ring read port.
// a two-entry command queue lets the input keep taking words while the back
// end waits on a stalled m_tready; results are held in the output register.
// reset empties the deque at once (front index and count to zero); the ring
// itself is not cleared.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_core #(
	parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic signed [bdeq_pkg::WORD_W-1:0]  s_tdata,  // value
	input  logic        [bdeq_pkg::KIND_W-1:0]  s_tuser,  // kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic signed [bdeq_pkg::WORD_W-1:0]  m_tdata,  // value_res
	output logic        [1:0]                   m_tuser,  // status
	output logic                                m_tlast
);

	logic           fe_valid;
	logic           fe_ready;
	bdeq_pkg::cmd_t fe_cmd;
	logic           be_valid;
	logic           be_ready;
	bdeq_pkg::cmd_t be_cmd;

	bdeq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (fe_valid),
		.cmd_ready (fe_ready),
		.cmd       (fe_cmd)
	);

	bdeq_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_cmd   (fe_cmd),
		.pop_valid  (be_valid),
		.pop_ready  (be_ready),
		.pop_cmd    (be_cmd)
	);

	bdeq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (be_valid),
		.cmd_ready (be_ready),
		.cmd       (be_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
